// ===== design/kms_pkg.sv =====
// Shared constants, types and helpers for the keypad matrix scanner.
`timescale 1ns / 1ps

package kms_pkg;

    // Matrix geometry and placement of row and column bits in the expander byte.
    localparam int ROWS        = 4;
    localparam int COLS        = 4;
    localparam int ROW_SHIFT   = 4;
    localparam int COL_SHIFT   = 0;
    localparam int QUEUE_DEPTH = 8;

    localparam int NKEYS   = ROWS * COLS;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int KEY_W   = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EVT_W   = KEY_W + 1;

    // Field widths of the stream items.
    localparam int CMD_W         = 2;
    localparam int ACTION_W      = 2;
    localparam int DEV_ADDR_W    = 7;
    localparam int BYTE_W        = 8;
    localparam int KEY_INDEX_W   = 4;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 24;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_DEVICE_ADDRESS = 2'd0;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_DONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_DONE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP        = 2'd3;

    // Result actions.
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd3;

    // Scan phases.
    localparam logic [1:0] PH_READY      = 2'd0;
    localparam logic [1:0] PH_WAIT_WRITE = 2'd1;
    localparam logic [1:0] PH_READ_RETRY = 2'd2;
    localparam logic [1:0] PH_WAIT_READ  = 2'd3;

    localparam logic [31:0] ROW_MASK = (32'd1 << ROWS) - 32'd1;
    localparam logic [31:0] COL_MASK = (32'd1 << COLS) - 32'd1;

    // Status of the event queue as seen by the sequencer.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Active-low row select over the column pull-up pattern.
    function automatic logic [BYTE_W-1:0] drive_pattern(input logic [ROW_W-1:0] row);
        logic [31:0] v;
        v = ((ROW_MASK ^ (32'd1 << row)) << ROW_SHIFT) | (COL_MASK << COL_SHIFT);
        return v[BYTE_W-1:0];
    endfunction

endpackage

// ===== design/keypad_matrix_scanner_unit.sv =====
// Top level of the keypad matrix scanner: command decode, column sequencer and result register.
`timescale 1ns / 1ps

// Each accepted item is a command: a tick asks for the row pattern write (or a read retry),
// a write done asks for the column read, a read done compares the returned columns with the
// stored key states, and a pop returns the oldest key event. Every item gives exactly one
// result item. A tick, a write done, a failed or unexpected read done and a pop of an empty
// queue load their result when accepted; a pop with an event waiting first passes the pop
// state for the registered queue read; a successful read done enters the scan state and a
// single compare-and-queue unit walks the columns one per cycle. The input is not ready
// while an item is at work, nor while an earlier result still waits in the output register
// and is not taken. A change that finds the event queue full leaves its key state untouched,
// so the next scan of that row reports it again. The expander bus address is written
// through the APB port at offset 0.
module keypad_matrix_scanner_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: bus_error, read_data.
    input  logic [kms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: command.
    input  logic [kms_pkg::CMD_W-1:0]           s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: target_address, drive_byte, event_valid, key_index,
    // key_pressed, comm_error.
    output logic [kms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: action.
    output logic [kms_pkg::ACTION_W-1:0]        m_axis_tuser,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kms_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [kms_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [kms_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    localparam logic [kms_pkg::ROW_W-1:0] LAST_ROW = kms_pkg::ROW_W'(kms_pkg::ROWS - 1);
    localparam logic [kms_pkg::COL_W-1:0] LAST_COL = kms_pkg::COL_W'(kms_pkg::COLS - 1);

    // Input item fields.
    logic [kms_pkg::CMD_W-1:0]   in_command;
    logic                        in_bus_error;
    logic [kms_pkg::BYTE_W-1:0]  in_read_data;
    logic                        in_accept;

    // Control and scan state.
    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [1:0]                  phase_reg;
    logic [1:0]                  phase_next;
    logic [kms_pkg::ROW_W-1:0]   row_reg;
    logic [kms_pkg::ROW_W-1:0]   row_next;
    logic [kms_pkg::COL_W-1:0]   col_reg;
    logic [kms_pkg::COL_W-1:0]   col_next;
    logic [kms_pkg::KEY_W-1:0]   key_ptr_reg;
    logic [kms_pkg::KEY_W-1:0]   key_ptr_next;
    logic [kms_pkg::BYTE_W-1:0]  col_data_reg;
    logic [kms_pkg::BYTE_W-1:0]  col_data_next;
    logic [kms_pkg::NKEYS-1:0]   key_down_reg;
    logic [kms_pkg::NKEYS-1:0]   key_down_next;
    logic [kms_pkg::DEV_ADDR_W-1:0] dev_addr_reg;

    // Result register.
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_load;
    logic [kms_pkg::ACTION_W-1:0]      out_action_reg;
    logic [kms_pkg::ACTION_W-1:0]      out_action_next;
    logic [kms_pkg::DEV_ADDR_W-1:0]    out_addr_reg;
    logic [kms_pkg::DEV_ADDR_W-1:0]    out_addr_next;
    logic [kms_pkg::BYTE_W-1:0]        out_drive_reg;
    logic [kms_pkg::BYTE_W-1:0]        out_drive_next;
    logic                              out_evt_valid_reg;
    logic                              out_evt_valid_next;
    logic [kms_pkg::KEY_INDEX_W-1:0]   out_key_index_reg;
    logic [kms_pkg::KEY_INDEX_W-1:0]   out_key_index_next;
    logic                              out_key_pressed_reg;
    logic                              out_key_pressed_next;
    logic                              out_comm_error_reg;
    logic                              out_comm_error_next;

    // Column compare unit and event queue.
    logic                              col_pressed;
    logic                              col_changed;
    logic                              fifo_push;
    logic                              fifo_pop;
    logic [kms_pkg::EVT_W-1:0]         fifo_push_data;
    logic [kms_pkg::EVT_W-1:0]         fifo_pop_data;
    kms_pkg::fifo_status_t             fifo_status;

    assign in_command   = s_axis_tuser;
    assign in_bus_error = s_axis_tdata[0];
    assign in_read_data = s_axis_tdata[kms_pkg::BYTE_W:1];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {2'b00, out_comm_error_reg, out_key_pressed_reg,
                            out_key_index_reg, out_evt_valid_reg, out_drive_reg,
                            out_addr_reg};

    // Configuration register access.
    assign pready = 1'b1;
    assign prdata = (paddr == kms_pkg::REG_DEVICE_ADDRESS)
                    ? kms_pkg::CFG_DATA_W'(dev_addr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= '0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr == kms_pkg::REG_DEVICE_ADDRESS))
        begin
            dev_addr_reg <= pwdata[kms_pkg::DEV_ADDR_W-1:0];
        end
    end

    // Shared column unit: a low bit means pressed; a change is taken only if the queue has room.
    assign col_pressed    = !col_data_reg[0];
    assign col_changed    = (key_down_reg[key_ptr_reg] != col_pressed);
    assign fifo_push_data = {col_pressed, key_ptr_reg};

    // Sequencer.
    always_comb
    begin
        state_next           = state_reg;
        phase_next           = phase_reg;
        row_next             = row_reg;
        col_next             = col_reg;
        key_ptr_next         = key_ptr_reg;
        col_data_next        = col_data_reg;
        key_down_next        = key_down_reg;
        fifo_push            = 1'b0;
        fifo_pop             = 1'b0;
        out_load             = 1'b0;
        out_action_next      = kms_pkg::ACT_NONE;
        out_addr_next        = '0;
        out_drive_next       = '0;
        out_evt_valid_next   = 1'b0;
        out_key_index_next   = '0;
        out_key_pressed_next = 1'b0;
        out_comm_error_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_command)
                        kms_pkg::CMD_TICK:
                        begin
                            out_load = 1'b1;
                            if (phase_reg == kms_pkg::PH_READY)
                            begin
                                out_action_next = kms_pkg::ACT_WRITE;
                                out_addr_next   = dev_addr_reg;
                                out_drive_next  = kms_pkg::drive_pattern(row_reg);
                                phase_next      = kms_pkg::PH_WAIT_WRITE;
                            end
                            else if (phase_reg == kms_pkg::PH_READ_RETRY)
                            begin
                                out_action_next = kms_pkg::ACT_READ;
                                out_addr_next   = dev_addr_reg;
                                phase_next      = kms_pkg::PH_WAIT_READ;
                            end
                        end
                        kms_pkg::CMD_WRITE_DONE:
                        begin
                            out_load = 1'b1;
                            if (phase_reg == kms_pkg::PH_WAIT_WRITE)
                            begin
                                if (in_bus_error)
                                begin
                                    out_comm_error_next = 1'b1;
                                    phase_next          = kms_pkg::PH_READY;
                                end
                                else
                                begin
                                    out_action_next = kms_pkg::ACT_READ;
                                    out_addr_next   = dev_addr_reg;
                                    phase_next      = kms_pkg::PH_WAIT_READ;
                                end
                            end
                        end
                        kms_pkg::CMD_READ_DONE:
                        begin
                            if (phase_reg != kms_pkg::PH_WAIT_READ)
                            begin
                                out_load = 1'b1;
                            end
                            else if (in_bus_error)
                            begin
                                out_load            = 1'b1;
                                out_comm_error_next = 1'b1;
                                phase_next          = kms_pkg::PH_READ_RETRY;
                            end
                            else
                            begin
                                // Align the first column to bit 0; bits past the byte read as 0.
                                col_data_next = in_read_data >> kms_pkg::COL_SHIFT;
                                col_next      = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        kms_pkg::CMD_POP:
                        begin
                            if (fifo_status.empty)
                            begin
                                out_load        = 1'b1;
                                out_action_next = kms_pkg::ACT_EVENT;
                            end
                            else
                            begin
                                fifo_pop   = 1'b1;
                                state_next = ST_POP;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (col_changed && !fifo_status.full)
                begin
                    fifo_push                  = 1'b1;
                    key_down_next[key_ptr_reg] = col_pressed;
                end
                col_data_next = col_data_reg >> 1;
                key_ptr_next  = key_ptr_reg + 1'b1;
                col_next      = col_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    // Row finished: advance and wrap, then report a plain result.
                    if (row_reg == LAST_ROW)
                    begin
                        row_next     = '0;
                        key_ptr_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    phase_next = kms_pkg::PH_READY;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                out_load             = 1'b1;
                out_action_next      = kms_pkg::ACT_EVENT;
                out_evt_valid_next   = 1'b1;
                out_key_index_next   =
                    kms_pkg::KEY_INDEX_W'(fifo_pop_data[kms_pkg::KEY_W-1:0]);
                out_key_pressed_next = fifo_pop_data[kms_pkg::KEY_W];
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register handshake.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= kms_pkg::PH_READY;
            row_reg       <= '0;
            col_reg       <= '0;
            key_ptr_reg   <= '0;
            key_down_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            key_ptr_reg   <= key_ptr_next;
            key_down_reg  <= key_down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        col_data_reg <= col_data_next;
        if (out_load)
        begin
            out_action_reg      <= out_action_next;
            out_addr_reg        <= out_addr_next;
            out_drive_reg       <= out_drive_next;
            out_evt_valid_reg   <= out_evt_valid_next;
            out_key_index_reg   <= out_key_index_next;
            out_key_pressed_reg <= out_key_pressed_next;
            out_comm_error_reg  <= out_comm_error_next;
        end
    end

    kms_event_fifo u_event_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_push_data),
        .pop       (fifo_pop),
        .pop_data  (fifo_pop_data),
        .status    (fifo_status)
    );

endmodule

// ===== design/kms_event_fifo.sv =====
// Event queue of key changes with a registered read port.
`timescale 1ns / 1ps

module kms_event_fifo
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [kms_pkg::EVT_W-1:0]  push_data,
    input  logic                       pop,
    output logic [kms_pkg::EVT_W-1:0]  pop_data,
    output kms_pkg::fifo_status_t      status
);

    logic [kms_pkg::EVT_W-1:0]   mem [kms_pkg::QUEUE_DEPTH];
    logic [kms_pkg::PTR_W-1:0]   head_reg;
    logic [kms_pkg::PTR_W-1:0]   head_next;
    logic [kms_pkg::PTR_W-1:0]   tail_reg;
    logic [kms_pkg::PTR_W-1:0]   tail_next;
    logic [kms_pkg::COUNT_W-1:0] count_reg;
    logic [kms_pkg::COUNT_W-1:0] count_next;
    logic [kms_pkg::EVT_W-1:0]   pop_data_reg;

    localparam logic [kms_pkg::PTR_W-1:0] LAST_PTR =
        kms_pkg::PTR_W'(kms_pkg::QUEUE_DEPTH - 1);
    localparam logic [kms_pkg::COUNT_W-1:0] FULL_COUNT =
        kms_pkg::COUNT_W'(kms_pkg::QUEUE_DEPTH);

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign pop_data     = pop_data_reg;

    // Pointer and occupancy update; the sequencer never pushes and pops together.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage with one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (pop)
        begin
            pop_data_reg <= mem[head_reg];
        end
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the keypad matrix scanner unit with a stream driver and monitor.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 8;

    // One command item as it travels on the input stream.
    typedef struct {
        logic [kms_pkg::CMD_W-1:0]  cmd;
        logic                       bus_err;
        logic [kms_pkg::BYTE_W-1:0] rdata;
    } scan_cmd_t;

    // One result item, unpacked.
    typedef struct packed {
        logic [kms_pkg::ACTION_W-1:0]    action;
        logic [kms_pkg::DEV_ADDR_W-1:0]  target;
        logic [kms_pkg::BYTE_W-1:0]      drive;
        logic                            ev_valid;
        logic [kms_pkg::KEY_INDEX_W-1:0] key;
        logic                            pressed;
        logic                            comm_err;
    } result_t;

    typedef struct packed {
        logic [kms_pkg::KEY_INDEX_W-1:0] key;
        logic                            pressed;
    } key_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [kms_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [kms_pkg::CMD_W-1:0]       s_axis_tuser = kms_pkg::CMD_TICK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [kms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [kms_pkg::ACTION_W-1:0]    m_axis_tuser;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [kms_pkg::CFG_ADDR_W-1:0] paddr = kms_pkg::REG_DEVICE_ADDRESS;
    logic [kms_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [kms_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // Stimulus and scoreboard storage.
    scan_cmd_t command_queue[$];
    result_t   expected_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_trigger = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        cycle_count = 0;

    // Predicted scanner state.
    logic [kms_pkg::DEV_ADDR_W-1:0] model_addr;
    logic [1:0]                     model_phase;
    logic [kms_pkg::ROW_W-1:0]      model_row;
    logic [kms_pkg::NKEYS-1:0]      model_keys;
    key_event_t                     model_events[$];

    // Generator steering state.
    int                         gen_row = 0;
    logic [kms_pkg::NKEYS-1:0]  key_matrix = '0;

    keypad_matrix_scanner_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // Applies one command to the predicted state and returns the result it should give.
    function automatic result_t advance_scanner(input scan_cmd_t it);
        result_t     r;
        key_event_t  ev;
        logic        down;
        int          idx;
        int          pos;
        logic [31:0] pattern;
        r = '0;
        case (it.cmd)
            kms_pkg::CMD_TICK:
            begin
                if (model_phase == kms_pkg::PH_READY)
                begin
                    pattern = ((((32'd1 << kms_pkg::ROWS) - 1) & ~(32'd1 << model_row))
                               << kms_pkg::ROW_SHIFT)
                              | (((32'd1 << kms_pkg::COLS) - 1) << kms_pkg::COL_SHIFT);
                    r.action = kms_pkg::ACT_WRITE;
                    r.target = model_addr;
                    r.drive = pattern[kms_pkg::BYTE_W-1:0];
                    model_phase = kms_pkg::PH_WAIT_WRITE;
                end
                else if (model_phase == kms_pkg::PH_READ_RETRY)
                begin
                    r.action = kms_pkg::ACT_READ;
                    r.target = model_addr;
                    model_phase = kms_pkg::PH_WAIT_READ;
                end
            end
            kms_pkg::CMD_WRITE_DONE:
            begin
                if (model_phase == kms_pkg::PH_WAIT_WRITE)
                begin
                    if (it.bus_err)
                    begin
                        r.comm_err = 1'b1;
                        model_phase = kms_pkg::PH_READY;
                    end
                    else
                    begin
                        r.action = kms_pkg::ACT_READ;
                        r.target = model_addr;
                        model_phase = kms_pkg::PH_WAIT_READ;
                    end
                end
            end
            kms_pkg::CMD_READ_DONE:
            begin
                if (model_phase == kms_pkg::PH_WAIT_READ)
                begin
                    if (it.bus_err)
                    begin
                        r.comm_err = 1'b1;
                        model_phase = kms_pkg::PH_READ_RETRY;
                    end
                    else
                    begin
                        // Queue each column change; a change that finds the queue full is kept
                        // pending by leaving the stored key state alone.
                        for (int c = 0; c < kms_pkg::COLS; c++)
                        begin
                            pos = kms_pkg::COL_SHIFT + c;
                            down = (pos > 7) ? 1'b1 : ~it.rdata[pos];
                            idx = int'(model_row) * kms_pkg::COLS + c;
                            if (idx < kms_pkg::NKEYS && model_keys[idx] != down
                                && model_events.size() < kms_pkg::QUEUE_DEPTH)
                            begin
                                ev.key = idx[kms_pkg::KEY_INDEX_W-1:0];
                                ev.pressed = down;
                                model_events.push_back(ev);
                                model_keys[idx] = down;
                            end
                        end
                        if (int'(model_row) == kms_pkg::ROWS - 1)
                            model_row = '0;
                        else
                            model_row = model_row + 1'b1;
                        model_phase = kms_pkg::PH_READY;
                    end
                end
            end
            default:
            begin
                r.action = kms_pkg::ACT_EVENT;
                if (model_events.size() > 0)
                begin
                    ev = model_events.pop_front();
                    r.ev_valid = 1'b1;
                    r.key = ev.key;
                    r.pressed = ev.pressed;
                end
            end
        endcase
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("act=%0d addr=%02h drive=%02h valid=%0d key=%0d down=%0d err=%0d",
                         r.action, r.target, r.drive, r.ev_valid, r.key, r.pressed, r.comm_err);
    endfunction

    // Input driver: when the bus is free, loads the next pending item unless a random idle is drawn.
    always @(posedge clk or negedge rst_n)
    begin : driver
        scan_cmd_t next_cmd;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= kms_pkg::CMD_TICK;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = command_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'b0, next_cmd.rdata, next_cmd.bus_err};
                s_axis_tuser <= next_cmd.cmd;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result against the oldest prediction, then predicts new items.
    always @(posedge clk)
    begin : monitor
        result_t   got;
        result_t   want;
        scan_cmd_t seen;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.action = m_axis_tuser;
                got.target = m_axis_tdata[6:0];
                got.drive = m_axis_tdata[14:7];
                got.ev_valid = m_axis_tdata[15];
                got.key = m_axis_tdata[19:16];
                got.pressed = m_axis_tdata[20];
                got.comm_err = m_axis_tdata[21];
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result item: %s", fmt_result(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected %s, got %s",
                                     fmt_result(want), fmt_result(got));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.cmd = s_axis_tuser;
                seen.bus_err = s_axis_tdata[0];
                seen.rdata = s_axis_tdata[8:1];
                expected_results.push_back(advance_scanner(seen));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_item(input logic [kms_pkg::CMD_W-1:0] cmd, input logic bus_err,
                            input logic [kms_pkg::BYTE_W-1:0] rdata);
        scan_cmd_t it;
        it.cmd = cmd;
        it.bus_err = bus_err;
        it.rdata = rdata;
        command_queue.push_back(it);
    endtask

    // One scan of a row with occasional bus failures and retries; returns the item count.
    task automatic add_scan(output int added);
        logic [kms_pkg::BYTE_W-1:0] d;
        added = 3;
        add_item(kms_pkg::CMD_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
        if ($urandom_range(9) == 0)
        begin
            add_item(kms_pkg::CMD_WRITE_DONE, 1'b1, 8'($urandom_range(255)));
            add_item(kms_pkg::CMD_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
            added += 2;
        end
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b0, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0)
        begin
            add_item(kms_pkg::CMD_READ_DONE, 1'b1, 8'($urandom_range(255)));
            add_item(kms_pkg::CMD_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
            added += 2;
        end
        // Keys change slowly so most rows report few or no changes.
        if ($urandom_range(9) < 4)
            key_matrix[$urandom_range(kms_pkg::NKEYS - 1)] ^= 1'b1;
        d = 8'($urandom_range(255));
        if ($urandom_range(9) != 0)
            d[kms_pkg::COL_SHIFT +: kms_pkg::COLS] =
                ~key_matrix[gen_row * kms_pkg::COLS +: kms_pkg::COLS];
        add_item(kms_pkg::CMD_READ_DONE, 1'b0, d);
        gen_row = (gen_row + 1) % kms_pkg::ROWS;
    endtask

    // Mostly well-formed scans, with bursts of pops and some random noise.
    task automatic add_random(input int count);
        int n;
        int pick;
        int added;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                add_scan(added);
                n += added;
            end
            else if (pick < 85)
            begin
                added = ($urandom_range(19) == 0) ? 12 : $urandom_range(6, 1);
                repeat (added)
                    add_item(kms_pkg::CMD_POP, 1'($urandom_range(1)),
                             8'($urandom_range(255)));
                n += added;
            end
            else
            begin
                added = $urandom_range(3, 1);
                repeat (added)
                    add_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                             8'($urandom_range(255)));
                n += added;
            end
        end
    endtask

    // Waits until every item has been sent and every result has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (command_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_device_address(input logic [kms_pkg::DEV_ADDR_W-1:0] value);
        logic [kms_pkg::CFG_DATA_W-1:0] word;
        word = $urandom();
        word[kms_pkg::DEV_ADDR_W-1:0] = value;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= kms_pkg::REG_DEVICE_ADDRESS;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_addr = value;
        @(negedge clk);
    endtask

    // Test sequence.
    initial
    begin
        model_addr = '0;
        model_phase = kms_pkg::PH_READY;
        model_row = '0;
        model_keys = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_device_address(7'h7F);
        send_idle_pct = 6;
        recv_idle_pct = 52;

        // Directed: empty pop, ignored ticks and out-of-phase completions, write and read
        // failures with retry, a row full of presses, queue overflow and row wrap.
        add_item(kms_pkg::CMD_POP, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_TICK, 1'b1, 8'hFF);
        add_item(kms_pkg::CMD_READ_DONE, 1'b1, 8'hFF);
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b1, 8'hFF);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b0, 8'hFF);
        add_item(kms_pkg::CMD_READ_DONE, 1'b1, 8'hFF);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_READ_DONE, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_READ_DONE, 1'b0, 8'hF0);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_READ_DONE, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_POP, 1'b1, 8'hFF);
        add_item(kms_pkg::CMD_TICK, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_WRITE_DONE, 1'b0, 8'h00);
        add_item(kms_pkg::CMD_READ_DONE, 1'b0, 8'hFF);
        repeat (3) add_item(kms_pkg::CMD_POP, 1'b0, 8'h00);

        // Random part with a long receiver hold-off while items keep coming.
        add_random(250);
        @(negedge clk);
        while (command_queue.size() > 200)
            @(negedge clk);
        hold_trigger = hold_trigger + 1;
        add_random(260);
        wait_drained();

        write_device_address(7'h00);
        send_idle_pct = 52;
        recv_idle_pct = 6;
        add_random(250);
        // The sender pauses here until every result has come back.
        wait_drained();
        add_random(250);
        wait_drained();

        write_device_address(7'($urandom_range(126, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(530);
        wait_drained();

        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
